[rtl/psp_pkg.sv]
// Shared types and fixed constants of the perspective screen projection unit.
// Used by every module and interface of the block; depends on nothing.
package psp_pkg;

    // coordinate and register widths
    localparam int COORD_W   = 32;
    localparam int DIST_W    = 31;
    localparam int DIM_W     = 13;
    localparam int CFG_IDX_W = 4;

    // products of the front end
    localparam int X_PROD_W  = COORD_W + DIST_W;        // d * |x|
    localparam int DA_W      = 2 * DIST_W;              // d * aspect
    localparam int Y_PROD_W  = DA_W + COORD_W;          // d * aspect * |y|

    // divider: quotient bits kept, the clamp limit sits at the top bit
    localparam int QUOT_W    = 41;
    localparam int REM_W     = COORD_W;
    localparam logic [QUOT_W-1:0] PLIM = {1'b1, {(QUOT_W-1){1'b0}}};

    // viewport mapping
    localparam int BASE_W    = QUOT_W + 1;
    localparam int SCALE_W   = DIM_W + 1;
    localparam int MUL_W     = BASE_W + SCALE_W;
    localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_DISTANCE   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ASPECT_RATIO    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEWPORT_WIDTH  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEWPORT_HEIGHT = 4'd3;

    // register reset values
    localparam logic [DIST_W-1:0] RST_VIEW_DISTANCE   = 31'd65536;
    localparam logic [DIST_W-1:0] RST_ASPECT_RATIO    = 31'd65536;
    localparam logic [DIM_W-1:0]  RST_VIEWPORT_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0]  RST_VIEWPORT_HEIGHT = 13'd480;

    // vertex data that travels alongside the arithmetic
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      skip;
        logic                      zero_z;
        logic                      neg_x;
        logic                      neg_y;
        logic                      last;
    } t_side;

    // one finished screen word
    typedef struct packed {
        logic signed [COORD_W-1:0] screen_x;
        logic signed [COORD_W-1:0] screen_y;
        logic signed [COORD_W-1:0] z_out;
        logic                      projected;
        logic                      divide_fault;
        logic                      last_out;
    } t_result;

endpackage

[rtl/psp_if.sv]
// Channel interfaces of the perspective screen projection unit: vertex in,
// screen word out and configuration write. Depends on psp_pkg.
interface psp_vtx_if;
    logic                               valid;
    logic                               ready;
    logic signed [psp_pkg::COORD_W-1:0] x_in;
    logic signed [psp_pkg::COORD_W-1:0] y_in;
    logic signed [psp_pkg::COORD_W-1:0] z_in;
    logic                               poly_active;
    logic                               poly_clipped;
    logic                               poly_backface;
    logic                               last_in;

    modport source (
        output valid, x_in, y_in, z_in, poly_active, poly_clipped, poly_backface, last_in,
        input  ready
    );
    modport sink (
        input  valid, x_in, y_in, z_in, poly_active, poly_clipped, poly_backface, last_in,
        output ready
    );
endinterface

interface psp_pix_if;
    logic                               valid;
    logic                               ready;
    logic signed [psp_pkg::COORD_W-1:0] screen_x;
    logic signed [psp_pkg::COORD_W-1:0] screen_y;
    logic signed [psp_pkg::COORD_W-1:0] z_out;
    logic                               projected;
    logic                               divide_fault;
    logic                               last_out;

    modport source (
        output valid, screen_x, screen_y, z_out, projected, divide_fault, last_out,
        input  ready
    );
    modport sink (
        input  valid, screen_x, screen_y, z_out, projected, divide_fault, last_out,
        output ready
    );
endinterface

interface psp_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [psp_pkg::CFG_IDX_W-1:0]    index;
    logic [psp_pkg::COORD_W-1:0]      data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

[rtl/perspective_screen_projection_unit.sv]
// Top level of the perspective screen projection unit: configuration registers,
// front end, divider, viewport mapping and output buffer. Depends on psp_pkg,
// psp_if, psp_front, psp_div, psp_map and psp_obuf.
//
//  channel  direction  handshake      word
//  i_vtx    in         valid/ready    camera-space vertex with polygon flags
//  o_pix    out        valid/ready    screen x/y, depth and status flags
//  i_cfg    in         valid/ready    register index and write data
//
// One vertex is taken every cycle while the pipeline advances; its word then passes
// through 3 front-end stages, 42 divider stages (a setup stage and 41 quotient
// stages, one quotient bit each), 3 mapping stages and the output register.
// Reset clears the valid bits and loads the register defaults; no clearing pass.
// A stall at o_pix fills the skid slot, then freezes the whole pipeline and
// drops i_vtx.ready; no word is lost or repeated. i_cfg is always ready.
module perspective_screen_projection_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    psp_vtx_if.sink     i_vtx,
    psp_pix_if.source   o_pix,
    psp_cfg_if.sink     i_cfg
);

    localparam int NUM_RAW = psp_pkg::Y_PROD_W - FRAC_BITS;
    localparam int NUM_MIN = psp_pkg::QUOT_W + psp_pkg::COORD_W;
    localparam int NUM_W   = (NUM_RAW > NUM_MIN) ? NUM_RAW : NUM_MIN;

    logic                             en;
    logic                             f_valid, d_valid, m_valid;
    psp_pkg::t_side                   f_side, d_side;
    logic [NUM_W-1:0]                 f_num_x, f_num_y;
    logic [psp_pkg::COORD_W-1:0]      f_den;
    logic [psp_pkg::QUOT_W-1:0]       d_quo_x, d_quo_y;
    psp_pkg::t_result                 m_result, out_word;

    logic [psp_pkg::DIST_W-1:0]       r_view_distance, r_aspect_ratio;
    logic [psp_pkg::DIM_W-1:0]        r_viewport_width, r_viewport_height;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_distance   <= psp_pkg::RST_VIEW_DISTANCE;
            r_aspect_ratio    <= psp_pkg::RST_ASPECT_RATIO;
            r_viewport_width  <= psp_pkg::RST_VIEWPORT_WIDTH;
            r_viewport_height <= psp_pkg::RST_VIEWPORT_HEIGHT;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                psp_pkg::CFG_VIEW_DISTANCE: begin
                    r_view_distance <= i_cfg.data[psp_pkg::DIST_W-1:0];
                end
                psp_pkg::CFG_ASPECT_RATIO: begin
                    r_aspect_ratio <= i_cfg.data[psp_pkg::DIST_W-1:0];
                end
                psp_pkg::CFG_VIEWPORT_WIDTH: begin
                    r_viewport_width <= i_cfg.data[psp_pkg::DIM_W-1:0];
                end
                psp_pkg::CFG_VIEWPORT_HEIGHT: begin
                    r_viewport_height <= i_cfg.data[psp_pkg::DIM_W-1:0];
                end
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    // vertex intake follows the pipeline advance
    assign i_vtx.ready = en;

    psp_front #(
        .FRAC_BITS (FRAC_BITS),
        .NUM_W     (NUM_W)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_valid         (i_vtx.valid),
        .i_x             (i_vtx.x_in),
        .i_y             (i_vtx.y_in),
        .i_z             (i_vtx.z_in),
        .i_active        (i_vtx.poly_active),
        .i_clipped       (i_vtx.poly_clipped),
        .i_backface      (i_vtx.poly_backface),
        .i_last          (i_vtx.last_in),
        .i_view_distance (r_view_distance),
        .i_aspect_ratio  (r_aspect_ratio),
        .o_valid         (f_valid),
        .o_side          (f_side),
        .o_num_x         (f_num_x),
        .o_num_y         (f_num_y),
        .o_den           (f_den)
    );

    psp_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_side  (f_side),
        .i_num_x (f_num_x),
        .i_num_y (f_num_y),
        .i_den   (f_den),
        .o_valid (d_valid),
        .o_side  (d_side),
        .o_quo_x (d_quo_x),
        .o_quo_y (d_quo_y)
    );

    psp_map #(
        .FRAC_BITS (FRAC_BITS)
    ) u_map (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (en),
        .i_valid           (d_valid),
        .i_side            (d_side),
        .i_quo_x           (d_quo_x),
        .i_quo_y           (d_quo_y),
        .i_viewport_width  (r_viewport_width),
        .i_viewport_height (r_viewport_height),
        .o_valid           (m_valid),
        .o_result          (m_result)
    );

    psp_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (m_valid),
        .i_data  (m_result),
        .o_en    (en),
        .o_valid (o_pix.valid),
        .o_data  (out_word),
        .i_ready (o_pix.ready)
    );

    // unpack the output word
    assign o_pix.screen_x     = out_word.screen_x;
    assign o_pix.screen_y     = out_word.screen_y;
    assign o_pix.z_out        = out_word.z_out;
    assign o_pix.projected    = out_word.projected;
    assign o_pix.divide_fault = out_word.divide_fault;
    assign o_pix.last_out     = out_word.last_out;

endmodule

[rtl/psp_front.sv]
// Front end: magnitudes, numerator products and the scaled y numerator.
// Three register stages. Depends on psp_pkg.
module psp_front #(
    parameter int FRAC_BITS = 16,
    parameter int NUM_W     = 77
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [psp_pkg::COORD_W-1:0]  i_x,
    input  logic signed [psp_pkg::COORD_W-1:0]  i_y,
    input  logic signed [psp_pkg::COORD_W-1:0]  i_z,
    input  logic                                i_active,
    input  logic                                i_clipped,
    input  logic                                i_backface,
    input  logic                                i_last,
    input  logic [psp_pkg::DIST_W-1:0]          i_view_distance,
    input  logic [psp_pkg::DIST_W-1:0]          i_aspect_ratio,
    output logic                                o_valid,
    output psp_pkg::t_side                      o_side,
    output logic [NUM_W-1:0]                    o_num_x,
    output logic [NUM_W-1:0]                    o_num_y,
    output logic [psp_pkg::COORD_W-1:0]         o_den
);

    localparam int LO_W = psp_pkg::DIST_W;
    localparam int PP_W = psp_pkg::COORD_W + LO_W;

    psp_pkg::t_side                   n1_side;
    logic [psp_pkg::COORD_W-1:0]      n1_ax, n1_ay, n1_az;
    logic [psp_pkg::Y_PROD_W-1:0]     n3_sum;

    logic                             r1_v, r2_v, r3_v;
    psp_pkg::t_side                   r1_side, r2_side, r3_side;
    logic [psp_pkg::COORD_W-1:0]      r1_ax, r1_ay, r1_az, r2_az, r3_az;
    logic [psp_pkg::DA_W-1:0]         r1_da;
    logic [psp_pkg::X_PROD_W-1:0]     r2_mx;
    logic [PP_W-1:0]                  r2_pyh, r2_pyl;
    logic [NUM_W-1:0]                 r3_nx, r3_ny;

    // sort out flags and signs, take magnitudes
    always_comb begin
        n1_side.x      = i_x;
        n1_side.y      = i_y;
        n1_side.z      = i_z;
        n1_side.skip   = !i_active || i_clipped || i_backface;
        n1_side.zero_z = (i_z == '0);
        n1_side.neg_x  = i_x[psp_pkg::COORD_W-1] ^ i_z[psp_pkg::COORD_W-1];
        n1_side.neg_y  = i_y[psp_pkg::COORD_W-1] ^ i_z[psp_pkg::COORD_W-1];
        n1_side.last   = i_last;
        n1_ax = i_x[psp_pkg::COORD_W-1] ? $unsigned(-i_x) : $unsigned(i_x);
        n1_ay = i_y[psp_pkg::COORD_W-1] ? $unsigned(-i_y) : $unsigned(i_y);
        n1_az = i_z[psp_pkg::COORD_W-1] ? $unsigned(-i_z) : $unsigned(i_z);
    end

    // join the y partial products and drop the fraction of the aspect factor
    always_comb begin
        n3_sum = {r2_pyh, {LO_W{1'b0}}} + {{LO_W{1'b0}}, r2_pyl};
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    // data stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_side <= n1_side;
            r1_ax   <= n1_ax;
            r1_ay   <= n1_ay;
            r1_az   <= n1_az;
            r1_da   <= i_view_distance * i_aspect_ratio;

            r2_side <= r1_side;
            r2_az   <= r1_az;
            r2_mx   <= r1_ax * i_view_distance;
            r2_pyh  <= r1_ay * r1_da[psp_pkg::DA_W-1:LO_W];
            r2_pyl  <= r1_ay * r1_da[LO_W-1:0];

            r3_side <= r2_side;
            r3_az   <= r2_az;
            r3_nx   <= NUM_W'(r2_mx);
            r3_ny   <= NUM_W'(n3_sum >> FRAC_BITS);
        end
    end

    assign o_valid = r3_v;
    assign o_side  = r3_side;
    assign o_num_x = r3_nx;
    assign o_num_y = r3_ny;
    assign o_den   = r3_az;

endmodule

[rtl/psp_div.sv]
// Pipelined restoring divider for the x and y lanes, one quotient bit a stage,
// with overflow clamp to the projection limit. Depends on psp_pkg.
module psp_div #(
    parameter int NUM_W = 77
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  psp_pkg::t_side                    i_side,
    input  logic [NUM_W-1:0]                  i_num_x,
    input  logic [NUM_W-1:0]                  i_num_y,
    input  logic [psp_pkg::COORD_W-1:0]       i_den,
    output logic                              o_valid,
    output psp_pkg::t_side                    o_side,
    output logic [psp_pkg::QUOT_W-1:0]        o_quo_x,
    output logic [psp_pkg::QUOT_W-1:0]        o_quo_y
);

    localparam int STEPS = psp_pkg::QUOT_W;
    localparam int TOP_W = NUM_W - psp_pkg::QUOT_W;

    logic [TOP_W-1:0]                  top_x, top_y, den_top;

    logic                              r_v      [0:STEPS];
    psp_pkg::t_side                    r_side   [0:STEPS];
    logic [psp_pkg::COORD_W-1:0]       r_den    [0:STEPS];
    logic                              r_ovf_x  [0:STEPS];
    logic                              r_ovf_y  [0:STEPS];
    logic [psp_pkg::REM_W-1:0]         r_rem_x  [0:STEPS];
    logic [psp_pkg::REM_W-1:0]         r_rem_y  [0:STEPS];
    logic [psp_pkg::QUOT_W-1:0]        r_quo_x  [0:STEPS];
    logic [psp_pkg::QUOT_W-1:0]        r_quo_y  [0:STEPS];

    // quotient too wide for the kept bits: clamp later
    always_comb begin
        top_x   = i_num_x[NUM_W-1:psp_pkg::QUOT_W];
        top_y   = i_num_y[NUM_W-1:psp_pkg::QUOT_W];
        den_top = TOP_W'(i_den);
    end

    // setup stage: overflow check and initial remainder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0]  <= i_side;
            r_den[0]   <= i_den;
            r_ovf_x[0] <= (top_x >= den_top);
            r_ovf_y[0] <= (top_y >= den_top);
            r_rem_x[0] <= psp_pkg::REM_W'(top_x);
            r_rem_y[0] <= psp_pkg::REM_W'(top_y);
            r_quo_x[0] <= i_num_x[psp_pkg::QUOT_W-1:0];
            r_quo_y[0] <= i_num_y[psp_pkg::QUOT_W-1:0];
        end
    end

    // one trial subtraction a stage; numerator bits leave the top, quotient bits enter
    for (genvar k = 1; k <= STEPS; k++) begin : g_step
        logic [psp_pkg::REM_W:0] t_x, t_y, dd;
        logic                    ge_x, ge_y;

        always_comb begin
            dd   = {1'b0, r_den[k-1]};
            t_x  = {r_rem_x[k-1], r_quo_x[k-1][psp_pkg::QUOT_W-1]};
            t_y  = {r_rem_y[k-1], r_quo_y[k-1][psp_pkg::QUOT_W-1]};
            ge_x = (t_x >= dd);
            ge_y = (t_y >= dd);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k]  <= r_side[k-1];
                r_den[k]   <= r_den[k-1];
                r_ovf_x[k] <= r_ovf_x[k-1];
                r_ovf_y[k] <= r_ovf_y[k-1];
                r_rem_x[k] <= ge_x ? psp_pkg::REM_W'(t_x - dd) : t_x[psp_pkg::REM_W-1:0];
                r_rem_y[k] <= ge_y ? psp_pkg::REM_W'(t_y - dd) : t_y[psp_pkg::REM_W-1:0];
                r_quo_x[k] <= {r_quo_x[k-1][psp_pkg::QUOT_W-2:0], ge_x};
                r_quo_y[k] <= {r_quo_y[k-1][psp_pkg::QUOT_W-2:0], ge_y};
            end
        end
    end

    // clamp the magnitude to the projection limit
    assign o_valid = r_v[STEPS];
    assign o_side  = r_side[STEPS];
    assign o_quo_x = (r_ovf_x[STEPS] || (r_quo_x[STEPS] > psp_pkg::PLIM))
                     ? psp_pkg::PLIM : r_quo_x[STEPS];
    assign o_quo_y = (r_ovf_y[STEPS] || (r_quo_y[STEPS] > psp_pkg::PLIM))
                     ? psp_pkg::PLIM : r_quo_y[STEPS];

endmodule

[rtl/psp_map.sv]
// Viewport mapping: offset by one, scale by size minus one, halve, saturate,
// then select pass-through. Three register stages. Depends on psp_pkg.
module psp_map #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  psp_pkg::t_side                i_side,
    input  logic [psp_pkg::QUOT_W-1:0]    i_quo_x,
    input  logic [psp_pkg::QUOT_W-1:0]    i_quo_y,
    input  logic [psp_pkg::DIM_W-1:0]     i_viewport_width,
    input  logic [psp_pkg::DIM_W-1:0]     i_viewport_height,
    output logic                          o_valid,
    output psp_pkg::t_result              o_result
);

    localparam int SAT_LO = psp_pkg::COORD_W - 1;
    localparam logic signed [psp_pkg::BASE_W-1:0] QONE =
        {{(psp_pkg::BASE_W-1){1'b0}}, 1'b1} << FRAC_BITS;

    logic signed [psp_pkg::BASE_W-1:0]   qx, qy;
    logic signed [psp_pkg::MUL_W-1:0]    vx, vy;
    logic                                sat_x, sat_y;
    psp_pkg::t_result                    n3_res;

    logic                                r1_v, r2_v, r3_v;
    psp_pkg::t_side                      r1_side, r2_side;
    logic signed [psp_pkg::BASE_W-1:0]   r1_bx, r1_by;
    logic signed [psp_pkg::SCALE_W-1:0]  r1_kx, r1_ky;
    logic signed [psp_pkg::MUL_W-1:0]    r2_px, r2_py;
    psp_pkg::t_result                    r3_res;

    // apply sign and offset: ONE + px and ONE - py
    always_comb begin
        qx = $signed({1'b0, i_quo_x});
        qy = $signed({1'b0, i_quo_y});
    end

    // halve with floor and saturate to the coordinate range
    always_comb begin
        vx    = r2_px >>> 1;
        vy    = r2_py >>> 1;
        sat_x = !((&vx[psp_pkg::MUL_W-1:SAT_LO]) || !(|vx[psp_pkg::MUL_W-1:SAT_LO]));
        sat_y = !((&vy[psp_pkg::MUL_W-1:SAT_LO]) || !(|vy[psp_pkg::MUL_W-1:SAT_LO]));

        n3_res.z_out    = r2_side.z;
        n3_res.last_out = r2_side.last;
        if (r2_side.skip) begin
            n3_res.screen_x     = r2_side.x;
            n3_res.screen_y     = r2_side.y;
            n3_res.projected    = 1'b0;
            n3_res.divide_fault = 1'b0;
        end else begin
            n3_res.screen_x = sat_x ? (vx[psp_pkg::MUL_W-1] ? psp_pkg::COORD_MIN
                                                            : psp_pkg::COORD_MAX)
                                    : vx[psp_pkg::COORD_W-1:0];
            n3_res.screen_y = sat_y ? (vy[psp_pkg::MUL_W-1] ? psp_pkg::COORD_MIN
                                                            : psp_pkg::COORD_MAX)
                                    : vy[psp_pkg::COORD_W-1:0];
            n3_res.projected    = 1'b1;
            n3_res.divide_fault = r2_side.zero_z || sat_x || sat_y;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    // data stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_side <= i_side;
            r1_bx   <= i_side.neg_x ? (QONE - qx) : (QONE + qx);
            r1_by   <= i_side.neg_y ? (QONE + qy) : (QONE - qy);
            r1_kx   <= $signed({1'b0, i_viewport_width})  - psp_pkg::SCALE_W'(1);
            r1_ky   <= $signed({1'b0, i_viewport_height}) - psp_pkg::SCALE_W'(1);

            r2_side <= r1_side;
            r2_px   <= r1_bx * r1_kx;
            r2_py   <= r1_by * r1_ky;

            r3_res  <= n3_res;
        end
    end

    assign o_valid  = r3_v;
    assign o_result = r3_res;

endmodule

[rtl/psp_obuf.sv]
// Output register with a skid slot; parts the pipeline advance from the
// downstream ready. Depends on psp_pkg.
module psp_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  psp_pkg::t_result  i_data,
    output logic              o_en,
    output logic              o_valid,
    output psp_pkg::t_result  o_data,
    input  logic              i_ready
);

    logic             push, pop;
    logic             r_main_v, r_skid_v;
    psp_pkg::t_result r_main, r_skid;

    // the pipeline advances while the skid slot is free
    assign o_en = !r_skid_v;
    assign push = o_en && i_valid;
    assign pop  = r_main_v && i_ready;

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (pop) begin
                r_skid_v <= 1'b0;
            end
        end else if (push) begin
            if (!r_main_v || pop) begin
                r_main_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (pop) begin
            r_main_v <= 1'b0;
        end
    end

    // word storage
    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (pop) begin
                r_main <= r_skid;
            end
        end else if (push) begin
            if (!r_main_v || pop) begin
                r_main <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

    assign o_valid = r_main_v;
    assign o_data  = r_main;

endmodule

[tb/tb.sv]
// Self-checking bench for perspective_screen_projection_unit: vertex words in,
// screen words out, compared field by field with a local projection predictor or
// typed expected words. Depends on psp_pkg, the psp_if interfaces and the unit's RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam longint QONE = longint'(1) << FRAC;
    localparam int NUM_PHASES = 10;
    localparam int PRESSURE_PHASE = 4;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 64;
    localparam int PRINT_CAP = 200;
    localparam logic [psp_pkg::CFG_IDX_W-1:0] CFG_FIRST_UNUSED =
        psp_pkg::CFG_IDX_W'(psp_pkg::CFG_VIEWPORT_HEIGHT + 1);
    localparam logic [psp_pkg::CFG_IDX_W-1:0] CFG_LAST_UNUSED = {psp_pkg::CFG_IDX_W{1'b1}};

    typedef struct packed {
        logic signed [psp_pkg::COORD_W-1:0] x;
        logic signed [psp_pkg::COORD_W-1:0] y;
        logic signed [psp_pkg::COORD_W-1:0] z;
        logic                               active;
        logic                               clipped;
        logic                               backface;
        logic                               last;
    } t_vertex;

    typedef struct {
        t_vertex          v;
        bit               typed;
        psp_pkg::t_result want;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    psp_vtx_if vtx_ch ();
    psp_pix_if pix_ch ();
    psp_cfg_if cfg_ch ();

    perspective_screen_projection_unit #(
        .FRAC_BITS(FRAC)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vtx  (vtx_ch),
        .o_pix  (pix_ch),
        .i_cfg  (cfg_ch)
    );

    // register copies used by the predictor
    logic [psp_pkg::DIST_W-1:0] exp_distance;
    logic [psp_pkg::DIST_W-1:0] aspect;
    logic [psp_pkg::DIM_W-1:0]  vp_width;
    logic [psp_pkg::DIM_W-1:0]  vp_height;

    psp_pkg::t_result pending_words[$];
    t_stim_row        directed[$];
    int               mismatch_count = 0;
    int               burst_left = 0;
    bit               hold_req = 1'b0;

    always #1 i_clk = ~i_clk;

    initial begin
        #400us;
        $display("FAILURE");
        $finish;
    end

    task automatic report_mismatch(string msg);
        if (mismatch_count < PRINT_CAP)
            $display("%0t: mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // floor(num/den), clamped to the projection limit
    function automatic logic [63:0] clamp_quotient(logic [127:0] num, logic [127:0] den);
        logic [127:0] q;
        q = num / den;
        return (q > {87'd0, psp_pkg::PLIM}) ? 64'(psp_pkg::PLIM) : q[63:0];
    endfunction

    // floor(scale2*base/2), saturated to the coordinate range
    function automatic logic [psp_pkg::COORD_W-1:0] to_screen(longint scale2, longint base,
                                                               inout bit sat);
        longint v;
        v = (scale2 * base) >>> 1;
        if (v > longint'($signed(psp_pkg::COORD_MAX))) begin
            sat = 1'b1;
            return psp_pkg::COORD_MAX;
        end
        if (v < longint'($signed(psp_pkg::COORD_MIN))) begin
            sat = 1'b1;
            return psp_pkg::COORD_MIN;
        end
        return v[psp_pkg::COORD_W-1:0];
    endfunction

    // screen word expected for one vertex under the current register values
    function automatic psp_pkg::t_result project_vertex(t_vertex v);
        psp_pkg::t_result r;
        longint           xs, ys, zs, px, py;
        logic [63:0]      ax, ay, az, qx, qy;
        bit               sat;
        xs = longint'($signed(v.x));
        ys = longint'($signed(v.y));
        zs = longint'($signed(v.z));
        r.z_out = v.z;
        r.last_out = v.last;
        // pass the vertex through for dead polygons
        if (!v.active || v.clipped || v.backface) begin
            r.screen_x = v.x;
            r.screen_y = v.y;
            r.projected = 1'b0;
            r.divide_fault = 1'b0;
            return r;
        end
        sat = 1'b0;
        if (zs == 0) begin
            sat = 1'b1;
            px = (xs >= 0) ? longint'(psp_pkg::PLIM) : -longint'(psp_pkg::PLIM);
            py = (ys >= 0) ? longint'(psp_pkg::PLIM) : -longint'(psp_pkg::PLIM);
        end else begin
            ax = (xs < 0) ? -xs : xs;
            ay = (ys < 0) ? -ys : ys;
            az = (zs < 0) ? -zs : zs;
            qx = clamp_quotient({97'd0, exp_distance} * {64'd0, ax}, {64'd0, az});
            qy = clamp_quotient({97'd0, exp_distance} * {97'd0, aspect} * {64'd0, ay},
                                {64'd0, az} << FRAC);
            px = ((xs < 0) != (zs < 0)) ? -longint'(qx) : longint'(qx);
            py = ((ys < 0) != (zs < 0)) ? -longint'(qy) : longint'(qy);
        end
        r.screen_x = to_screen(longint'(vp_width) - 1, QONE + px, sat);
        r.screen_y = to_screen(longint'(vp_height) - 1, QONE - py, sat);
        r.projected = 1'b1;
        r.divide_fault = sat;
        return r;
    endfunction

    function automatic t_stim_row row(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                      bit act, bit clip, bit back, bit last,
                                      bit typed = 1'b0, logic [31:0] sx = '0,
                                      logic [31:0] sy = '0, bit fault = 1'b0);
        t_stim_row s;
        s.v = '{x: x, y: y, z: z, active: act, clipped: clip, backface: back, last: last};
        s.typed = typed;
        s.want.screen_x = sx;
        s.want.screen_y = sy;
        s.want.z_out = z;
        s.want.projected = act & !clip & !back;
        s.want.divide_fault = fault;
        s.want.last_out = last;
        return s;
    endfunction

    function automatic t_vertex random_vertex();
        t_vertex     v;
        int unsigned pick, zmag;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            // plausible scene: depth of an eighth to 200 units, x and y near the frustum
            zmag = $urandom_range(8192, 13107200);
            v.z = ($urandom_range(0, 7) == 0) ? -zmag : zmag;
            v.x = $urandom_range(0, 4 * zmag) - 2 * zmag;
            v.y = $urandom_range(0, 4 * zmag) - 2 * zmag;
        end else if (pick < 8) begin
            v.x = $urandom();
            v.y = $urandom();
            v.z = $urandom();
        end else if (pick == 8) begin
            v.x = $urandom();
            v.y = $urandom();
            case ($urandom_range(0, 4))
                0: v.z = '0;
                1: v.z = 32'sd1;
                2: v.z = -32'sd1;
                3: v.z = psp_pkg::COORD_MIN;
                default: v.z = psp_pkg::COORD_MAX;
            endcase
        end else begin
            v.x = $urandom_range(0, 255) - 128;
            v.y = $urandom_range(0, 255) - 128;
            v.z = $urandom_range(0, 255) - 128;
        end
        if ($urandom_range(0, 3) != 0) begin
            v.active = 1'b1;
            v.clipped = 1'b0;
            v.backface = 1'b0;
        end else begin
            v.active = 1'($urandom_range(0, 1));
            v.clipped = 1'($urandom_range(0, 1));
            v.backface = 1'($urandom_range(0, 1));
        end
        v.last = ($urandom_range(0, 7) == 0);
        return v;
    endfunction

    // keep the low bits of a register value, fill the rest with noise
    function automatic logic [psp_pkg::COORD_W-1:0] with_noise(
        logic [psp_pkg::COORD_W-1:0] value, int bits);
        logic [psp_pkg::COORD_W-1:0] mask;
        mask = (32'd1 << bits) - 1;
        return ($urandom() & ~mask) | (value & mask);
    endfunction

    task automatic write_reg(logic [psp_pkg::CFG_IDX_W-1:0] idx,
                             logic [psp_pkg::COORD_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        case (idx)
            psp_pkg::CFG_VIEW_DISTANCE:   exp_distance = value[psp_pkg::DIST_W-1:0];
            psp_pkg::CFG_ASPECT_RATIO:    aspect       = value[psp_pkg::DIST_W-1:0];
            psp_pkg::CFG_VIEWPORT_WIDTH:  vp_width     = value[psp_pkg::DIM_W-1:0];
            psp_pkg::CFG_VIEWPORT_HEIGHT: vp_height    = value[psp_pkg::DIM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_view(logic [psp_pkg::DIST_W-1:0] d, logic [psp_pkg::DIST_W-1:0] a,
                             logic [psp_pkg::DIM_W-1:0] w, logic [psp_pkg::DIM_W-1:0] h);
        write_reg(psp_pkg::CFG_VIEW_DISTANCE, with_noise(32'(d), psp_pkg::DIST_W));
        write_reg(psp_pkg::CFG_ASPECT_RATIO, with_noise(32'(a), psp_pkg::DIST_W));
        write_reg(psp_pkg::CFG_VIEWPORT_WIDTH, with_noise(32'(w), psp_pkg::DIM_W));
        write_reg(psp_pkg::CFG_VIEWPORT_HEIGHT, with_noise(32'(h), psp_pkg::DIM_W));
        // an unmapped index must leave every register alone
        write_reg(psp_pkg::CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_UNUSED)),
                  $urandom());
        cfg_ch.valid <= 1'b0;
    endtask

    // put one vertex word on the channel and hold it until taken
    task automatic offer_vertex(t_vertex v, psp_pkg::t_result want);
        pending_words.push_back(want);
        vtx_ch.valid         <= 1'b1;
        vtx_ch.x_in          <= v.x;
        vtx_ch.y_in          <= v.y;
        vtx_ch.z_in          <= v.z;
        vtx_ch.poly_active   <= v.active;
        vtx_ch.poly_clipped  <= v.clipped;
        vtx_ch.poly_backface <= v.backface;
        vtx_ch.last_in       <= v.last;
        do @(posedge i_clk); while (vtx_ch.ready !== 1'b1);
    endtask

    // send in bursts, with an idle gap between them
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            vtx_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
        end
    endtask

    // receiver: random stall pattern, plus one long hold-off on request
    int hold_left = 0;
    int run_left = 0;
    bit hold_seen = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            pix_ch.ready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            pix_ch.ready <= 1'b0;
        end else if (run_left != 0) begin
            run_left <= run_left - 1;
        end else begin
            case ($urandom_range(0, 3))
                0: begin
                    pix_ch.ready <= 1'b0;
                    run_left <= $urandom_range(0, 5);
                end
                3: begin
                    pix_ch.ready <= 1'b1;
                    run_left <= $urandom_range(20, 80);
                end
                default: begin
                    pix_ch.ready <= 1'b1;
                    run_left <= $urandom_range(0, 15);
                end
            endcase
        end
    end

    // check every screen word taken against the oldest one owed
    psp_pkg::t_result owed;

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1) begin
            if (pending_words.size() == 0) begin
                report_mismatch($sformatf("screen word %h/%h with none owed",
                                          pix_ch.screen_x, pix_ch.screen_y));
            end else begin
                owed = pending_words.pop_front();
                if (pix_ch.screen_x !== owed.screen_x)
                    report_mismatch($sformatf("screen_x %h, expected %h",
                                              pix_ch.screen_x, owed.screen_x));
                if (pix_ch.screen_y !== owed.screen_y)
                    report_mismatch($sformatf("screen_y %h, expected %h",
                                              pix_ch.screen_y, owed.screen_y));
                if (pix_ch.z_out !== owed.z_out)
                    report_mismatch($sformatf("z_out %h, expected %h",
                                              pix_ch.z_out, owed.z_out));
                if (pix_ch.projected !== owed.projected)
                    report_mismatch($sformatf("projected %b, expected %b",
                                              pix_ch.projected, owed.projected));
                if (pix_ch.divide_fault !== owed.divide_fault)
                    report_mismatch($sformatf("divide_fault %b, expected %b",
                                              pix_ch.divide_fault, owed.divide_fault));
                if (pix_ch.last_out !== owed.last_out)
                    report_mismatch($sformatf("last_out %b, expected %b",
                                              pix_ch.last_out, owed.last_out));
            end
        end
    end

    initial begin
        t_vertex                    v;
        psp_pkg::t_result           want;
        int                         count;
        logic [psp_pkg::DIST_W-1:0] d, a;
        logic [psp_pkg::DIM_W-1:0]  w, h;

        i_rst_n              <= 1'b0;
        vtx_ch.valid         <= 1'b0;
        vtx_ch.x_in          <= '0;
        vtx_ch.y_in          <= '0;
        vtx_ch.z_in          <= '0;
        vtx_ch.poly_active   <= 1'b0;
        vtx_ch.poly_clipped  <= 1'b0;
        vtx_ch.poly_backface <= 1'b0;
        vtx_ch.last_in       <= 1'b0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= '0;
        cfg_ch.data          <= '0;
        exp_distance = psp_pkg::RST_VIEW_DISTANCE;
        aspect       = psp_pkg::RST_ASPECT_RATIO;
        vp_width     = psp_pkg::RST_VIEWPORT_WIDTH;
        vp_height    = psp_pkg::RST_VIEWPORT_HEIGHT;

        // directed words under the reset register values
        directed = {
            // centre of the screen, then the two corners of the unit square
            row(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 1, 0, 0, 0,
                1, 32'h013F_8000, 32'h00EF_8000, 0),
            row(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1, 0, 0, 0,
                1, 32'h027F_0000, 32'h0000_0000, 0),
            row(32'hFFFF_0000, 32'hFFFF_0000, 32'h0001_0000, 1, 0, 0, 1,
                1, 32'h0000_0000, 32'h01DF_0000, 0),
            // zero depth saturates by the signs of x and y
            row(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1, 0, 0, 0,
                1, 32'h7FFF_FFFF, 32'h8000_0000, 1),
            row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1, 0, 0, 1,
                1, 32'h8000_0000, 32'h7FFF_FFFF, 1),
            // dead polygons pass through, zero depth included
            row(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 0, 0, 0, 0,
                1, 32'h7FFF_FFFF, 32'h8000_0000, 0),
            row(32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678, 1, 1, 0, 0,
                1, 32'h8000_0000, 32'h7FFF_FFFF, 0),
            row(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1, 0, 1, 1,
                1, 32'hFFFF_FFFF, 32'h0000_0000, 0),
            row(32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'h8000_0000, 1, 1, 1, 1,
                1, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 0),
            row(32'hC3C3_3C3C, 32'h3C3C_C3C3, 32'h0001_0000, 0, 1, 1, 1),
            // quotient clamp and output saturation
            row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 1, 0, 0, 0,
                1, 32'h7FFF_FFFF, 32'h8000_0000, 1),
            row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 0, 0, 0),
            row(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1, 0, 0, 1),
            row(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 0, 0, 0),
            // negative depth flips the screen
            row(32'h0000_8000, 32'hFFFD_0000, 32'hFFFF_FFFF, 1, 0, 0, 0),
            row(32'hFFFB_0000, 32'h0002_0000, 32'hFFFC_0000, 1, 0, 0, 1),
            // truncation toward zero of tiny quotients, then exact quotients
            row(32'h0000_0001, 32'hFFFF_FFFF, 32'h0002_0000, 1, 0, 0, 0),
            row(32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 1, 0, 0, 1),
            row(32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 1, 0, 0, 0),
            row(32'h0003_0000, 32'h0001_0000, 32'h0004_0000, 1, 0, 0, 0),
            row(32'hFFFE_0000, 32'hFFFF_8000, 32'h0000_4000, 1, 0, 0, 1)
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            want = directed[i].typed ? directed[i].want : project_vertex(directed[i].v);
            offer_vertex(directed[i].v, want);
            pace();
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            // drain before touching the registers
            vtx_ch.valid <= 1'b0;
            while (pending_words.size() != 0) @(posedge i_clk);

            case (phase)
                0: begin
                    // zero distance, zero aspect, zero-sized viewport
                    d = '0; a = '0; w = '0; h = '0;
                end
                1: begin
                    d = '1; a = '1; w = '1; h = '1;
                end
                2: begin
                    // one-pixel viewport maps every projected vertex to the origin
                    d = psp_pkg::DIST_W'(QONE); a = psp_pkg::DIST_W'(QONE);
                    w = 13'd1; h = 13'd1;
                end
                3: begin
                    d = psp_pkg::DIST_W'(2 * QONE); a = psp_pkg::DIST_W'(QONE * 3 / 4);
                    w = 13'd4096; h = 13'd4096;
                end
                default: begin
                    d = ($urandom_range(0, 2) == 0)
                        ? psp_pkg::DIST_W'($urandom())
                        : psp_pkg::DIST_W'($urandom_range(16384, 524288));
                    a = ($urandom_range(0, 2) == 0)
                        ? psp_pkg::DIST_W'($urandom())
                        : psp_pkg::DIST_W'($urandom_range(32768, 131072));
                    w = ($urandom_range(0, 2) == 0)
                        ? psp_pkg::DIM_W'($urandom_range(0, 8191))
                        : psp_pkg::DIM_W'($urandom_range(160, 1920));
                    h = ($urandom_range(0, 2) == 0)
                        ? psp_pkg::DIM_W'($urandom_range(0, 8191))
                        : psp_pkg::DIM_W'($urandom_range(120, 1080));
                end
            endcase
            load_view(d, a, w, h);

            // back-to-back words against a long receiver hold-off
            if (phase == PRESSURE_PHASE)
                hold_req <= ~hold_req;
            count = (phase == PRESSURE_PHASE) ? 120 : 32;
            repeat (count) begin
                v = random_vertex();
                offer_vertex(v, project_vertex(v));
                if (phase != PRESSURE_PHASE)
                    pace();
            end
        end

        vtx_ch.valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
rtl/psp_pkg.sv
rtl/psp_if.sv
rtl/psp_front.sv
rtl/psp_div.sv
rtl/psp_map.sv
rtl/psp_obuf.sv
rtl/perspective_screen_projection_unit.sv
tb/tb.sv
